[src/assert_macros.svh]
// Assertion macros shared by the RTL of the conflict checker.
// Depends on nothing; every macro samples on clk and is disabled in rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold at every clock edge.
`define PCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Antecedent in one cycle implies the consequent in the next cycle.
`define PCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

[src/pcc_pkg.sv]
// Package of the periodic task conflict checker: sizes, heap entry type
// and the heap ordering and saturation helpers. Depends on nothing.
package pcc_pkg;
  localparam int HEAP_DEPTH = 1024;
  localparam int TIME_WIDTH = 32;
  localparam int IN_W = 31;
  localparam int ADDR_W = $clog2(HEAP_DEPTH);
  localparam int CNT_W = ADDR_W + 1;
  localparam int WIDE_W = 64;
  localparam logic [WIDE_W-1:0] TMAX = (64'd1 << TIME_WIDTH) - 64'd1;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] t_start;
    logic [TIME_WIDTH-1:0] t_stop;
    logic [TIME_WIDTH-1:0] t_period;
    logic [CNT_W-1:0]      order;
  } entry_t;

  function automatic logic [TIME_WIDTH-1:0] sat_time(input logic [WIDE_W-1:0] v);
    logic [WIDE_W-1:0] r;
    r = (v > TMAX) ? TMAX : v;
    return r[TIME_WIDTH-1:0];
  endfunction

  // Earlier start wins; equal starts fall back to arrival order.
  function automatic logic earlier(input entry_t a, input entry_t b);
    if (a.t_start != b.t_start) return a.t_start < b.t_start;
    return a.order < b.order;
  endfunction
endpackage

[src/periodic_task_conflict_checker.sv]
// Top level of the periodic task conflict checker: heap memory and its
// read-modify-write sequencer. Depends on pcc_pkg and assert_macros.svh.
//
// Usage: a task beat is accepted on a clock edge with start high and busy
// low; its fields are has_task, start_time, end_time, period, last_task.
// The horizon register is written by horizon_we/horizon_wdata; the user
// must write it only while the block is idle, which the block itself
// does not enforce. Accepted tasks with a start below the horizon go into
// a min-heap held in one synchronous memory (one read and one write port,
// registered read data). Loading a task sifts it up: each level reads the
// parent, then compares and writes the winner. On a beat with last_task
// high the heap is checked: each pop takes the top, sifts the last entry
// down from the root and flags a conflict if the popped stop lies past the
// new top's start; a periodic task is re-inserted with its next instance
// while that start stays below the horizon. One result beat then appears
// for exactly one cycle with done high, carrying conflict and overflow;
// the heap is emptied. The receiver cannot stall. Synchronous reset empties
// the heap and clears the horizon; the memory itself needs no clearing.
module periodic_task_conflict_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       has_task,
  input  logic [pcc_pkg::IN_W-1:0]   start_time,
  input  logic [pcc_pkg::IN_W-1:0]   end_time,
  input  logic [pcc_pkg::IN_W-1:0]   period,
  input  logic                       last_task,
  input  logic                       horizon_we,
  input  logic [pcc_pkg::IN_W-1:0]   horizon_wdata,
  output logic                       done,
  output logic                       conflict,
  output logic                       overflow
);
  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_UP_RD, S_UP_CMP, S_CHK_RD, S_CHK_EVAL,
    S_POP_LD, S_DN_RDL, S_DN_RDR, S_DN_CMP, S_DONE
  } state_t;

  localparam int AW = pcc_pkg::ADDR_W;
  localparam int CW = pcc_pkg::CNT_W;
  localparam int TW = pcc_pkg::TIME_WIDTH;
  localparam int WW = pcc_pkg::WIDE_W;

  state_t state;
  logic [pcc_pkg::IN_W-1:0] horizon;
  logic [CW-1:0] count;
  logic [CW-1:0] arrival;
  logic          ovf_seen;
  logic          checking;
  logic          conf_hit;
  logic          pend;
  pcc_pkg::entry_t cur;
  pcc_pkg::entry_t lft;
  pcc_pkg::entry_t popped;
  logic [AW-1:0] idx;
  logic          in_has;
  logic          in_last;
  logic [TW-1:0] in_s;
  logic [TW-1:0] in_e;
  logic [TW-1:0] in_p;

  pcc_pkg::entry_t mem [pcc_pkg::HEAP_DEPTH];
  pcc_pkg::entry_t rdata;
  pcc_pkg::entry_t wdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          we;

  // Child and parent positions of the current slot.
  logic [CW:0]   left_pos;
  logic [CW:0]   right_pos;
  logic [AW-1:0] parent_pos;
  logic          right_ok;
  logic          pick_l;
  logic          pick_r;
  pcc_pkg::entry_t best;
  logic [WW-1:0] hz_wide;
  logic [WW-1:0] next_start;
  logic [WW-1:0] next_stop;
  logic          reinsert;
  logic          top_done;
  logic          load_ok;

  always_comb begin
    left_pos   = {idx, 1'b0} + (CW+1)'(1);
    right_pos  = {idx, 1'b0} + (CW+1)'(2);
    parent_pos = AW'((idx - AW'(1)) >> 1);
    right_ok   = right_pos < {1'b0, count};
    pick_l     = pcc_pkg::earlier(lft, cur);
    best       = pick_l ? lft : cur;
    pick_r     = right_ok && pcc_pkg::earlier(rdata, best);
    hz_wide    = WW'(horizon);
    next_start = WW'(popped.t_start) + WW'(popped.t_period);
    next_stop  = WW'(popped.t_stop) + WW'(popped.t_period);
    reinsert   = (popped.t_period != '0) &&
                 (WW'(pcc_pkg::sat_time(next_start)) < hz_wide);
    top_done   = (count == '0) || (WW'(rdata.t_start) >= hz_wide);
    load_ok    = in_has && (WW'(in_s) < hz_wide);
  end

  // Memory port control.
  always_comb begin
    raddr = '0;
    waddr = idx;
    wdata = cur;
    we    = 1'b0;
    case (state)
      S_UP_RD: begin
        raddr = parent_pos;
        we    = (idx == '0);
      end
      S_UP_CMP: begin
        we    = 1'b1;
        wdata = pcc_pkg::earlier(cur, rdata) ? rdata : cur;
      end
      S_CHK_EVAL: begin
        raddr = AW'(count - CW'(1));
      end
      S_DN_RDL: begin
        raddr = AW'(left_pos);
        we    = left_pos >= {1'b0, count};
      end
      S_DN_RDR: begin
        raddr = AW'(right_pos);
      end
      S_DN_CMP: begin
        we    = 1'b1;
        wdata = pick_r ? rdata : best;
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      horizon  <= '0;
      count    <= '0;
      arrival  <= '0;
      ovf_seen <= 1'b0;
      checking <= 1'b0;
      conf_hit <= 1'b0;
      pend     <= 1'b0;
      done     <= 1'b0;
      conflict <= 1'b0;
      overflow <= 1'b0;
    end else begin
      done <= 1'b0;
      if (horizon_we) begin
        horizon <= horizon_wdata;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            in_has  <= has_task;
            in_last <= last_task;
            in_s    <= pcc_pkg::sat_time(WW'(start_time));
            in_e    <= pcc_pkg::sat_time(WW'(end_time));
            in_p    <= pcc_pkg::sat_time(WW'(period));
            state   <= S_LOAD;
          end
        end
        S_LOAD: begin
          checking <= in_last;
          if (load_ok && count < CW'(pcc_pkg::HEAP_DEPTH)) begin
            cur     <= '{t_start: in_s, t_stop: in_e, t_period: in_p, order: arrival};
            idx     <= AW'(count);
            count   <= count + CW'(1);
            arrival <= arrival + CW'(1);
            state   <= S_UP_RD;
          end else begin
            if (load_ok) begin
              ovf_seen <= 1'b1;
            end
            state <= in_last ? S_CHK_RD : S_IDLE;
          end
        end
        S_UP_RD: begin
          if (idx == '0) begin
            state <= checking ? S_CHK_RD : S_IDLE;
          end else begin
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (pcc_pkg::earlier(cur, rdata)) begin
            idx   <= parent_pos;
            state <= S_UP_RD;
          end else begin
            state <= checking ? S_CHK_RD : S_IDLE;
          end
        end
        S_CHK_RD: begin
          state <= S_CHK_EVAL;
        end
        S_CHK_EVAL: begin
          // rdata holds the heap top here.
          if (pend) begin
            pend <= 1'b0;
            if (count != '0 && popped.t_stop > rdata.t_start) begin
              conf_hit <= 1'b1;
              state    <= S_DONE;
            end else if (reinsert) begin
              cur <= '{t_start: pcc_pkg::sat_time(next_start),
                       t_stop: pcc_pkg::sat_time(next_stop),
                       t_period: popped.t_period, order: popped.order};
              idx   <= AW'(count);
              count <= count + CW'(1);
              state <= S_UP_RD;
            end else begin
              state <= S_CHK_RD;
            end
          end else if (top_done) begin
            state <= S_DONE;
          end else begin
            pend   <= 1'b1;
            popped <= rdata;
            count  <= count - CW'(1);
            state  <= (count == CW'(1)) ? S_CHK_RD : S_POP_LD;
          end
        end
        S_POP_LD: begin
          cur   <= rdata;
          idx   <= '0;
          state <= S_DN_RDL;
        end
        S_DN_RDL: begin
          state <= (left_pos >= {1'b0, count}) ? S_CHK_RD : S_DN_RDR;
        end
        S_DN_RDR: begin
          lft   <= rdata;
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (pick_r) begin
            idx   <= AW'(right_pos);
            state <= S_DN_RDL;
          end else if (pick_l) begin
            idx   <= AW'(left_pos);
            state <= S_DN_RDL;
          end else begin
            state <= S_CHK_RD;
          end
        end
        S_DONE: begin
          done     <= 1'b1;
          conflict <= conf_hit;
          overflow <= ovf_seen;
          count    <= '0;
          arrival  <= '0;
          ovf_seen <= 1'b0;
          conf_hit <= 1'b0;
          checking <= 1'b0;
          pend     <= 1'b0;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  `PCC_ASSERT(a_count_range, count <= CW'(pcc_pkg::HEAP_DEPTH), "heap count past depth")
  `PCC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `PCC_ASSERT_NEXT(a_done_clears, state == S_DONE, done && count == '0 && !busy,
                   "result beat did not empty the heap")
endmodule
